// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Types and constants shared by the HSV to RGB converter files.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned CompW   = 8;
  localparam int unsigned SectorW = 3;
  localparam int unsigned ScaleW  = CompW + 1;

  typedef logic [CompW-1:0]   comp_t;
  typedef logic [SectorW-1:0] sector_t;
  typedef logic [ScaleW-1:0]  scale_t;

  // Sector codes, one per sixth of the colour circle
  localparam sector_t SEC_RED_YELLOW    = 3'd0;
  localparam sector_t SEC_YELLOW_GREEN  = 3'd1;
  localparam sector_t SEC_GREEN_CYAN    = 3'd2;
  localparam sector_t SEC_CYAN_BLUE     = 3'd3;
  localparam sector_t SEC_BLUE_MAGENTA  = 3'd4;
  localparam sector_t SEC_MAGENTA_RED   = 3'd5;

  typedef struct packed {
    comp_t hue;
    comp_t saturation;
    comp_t brightness;
  } hsv_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } rgb_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsv2rgb_mix.sv -----
// Sector mapping: routes top, middle and offset levels onto red, green and blue.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_mix (
  input  wire hsv2rgb_pkg::sector_t sector,
  input  wire hsv2rgb_pkg::comp_t   hi,
  input  wire hsv2rgb_pkg::comp_t   mid,
  input  wire hsv2rgb_pkg::comp_t   lo,
  output hsv2rgb_pkg::rgb_t         rgb
);

  always_comb begin
    case (sector)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        rgb = '{red: hi,  green: mid, blue: lo};
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        rgb = '{red: mid, green: hi,  blue: lo};
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        rgb = '{red: lo,  green: hi,  blue: mid};
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        rgb = '{red: lo,  green: mid, blue: hi};
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        rgb = '{red: mid, green: lo,  blue: hi};
      end
      default: begin
        // magenta to red, and the unused codes
        rgb = '{red: hi,  green: lo,  blue: mid};
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_converter.sv -----
// Top level of the pipelined 8-bit HSV to RGB colour converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one 8-bit hue/saturation/brightness item into one 8-bit red/green/blue
// item. The block is a three-stage pipeline and takes one item every clock while
// the result side keeps up. An accepted item passes the stage 1, stage 2 and
// stage 3 registers in turn and is then offered on the result channel. Stage 1
// forms chroma (saturation times brightness, top 8 bits) and splits hue times
// six into a sector number and a position within the sector pair; stage 2 forms
// the middle level from chroma and that position (the second multiplier) together
// with the offset, brightness minus chroma; stage 3 adds the offset to the middle
// level and routes top, middle and offset onto the three colours. The
// two multipliers, one per stage, set the clock. Every stage holds its item
// while the stage after it is full and stalled, so back-pressure on out_ready
// reaches in_ready without losing or repeating an item. A brightness of zero
// gives black through the arithmetic itself: chroma and offset are then zero.
module hsv_to_rgb_converter (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire hsv2rgb_pkg::hsv_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output hsv2rgb_pkg::rgb_t   out_data
);

  // ---------------------------------------------------------------
  // Stage handshake: a stage takes an item when it is empty or its
  // current item moves on in the same cycle.
  // ---------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // ---------------------------------------------------------------
  // Stage 1: chroma and hue scaling
  // ---------------------------------------------------------------
  hsv2rgb_pkg::comp_t   s1_chroma_r, s1_chroma_nxt;
  hsv2rgb_pkg::comp_t   s1_bright_r;
  hsv2rgb_pkg::scale_t  s1_scale_r, s1_scale_nxt;
  hsv2rgb_pkg::sector_t s1_sector_r, s1_sector_nxt;

  logic [2*hsv2rgb_pkg::CompW-1:0] sv_prod;
  logic [10:0]                     hue_x6;
  logic [8:0]                      hue_pos;

  always_comb begin
    sv_prod       = in_data.saturation * in_data.brightness;
    s1_chroma_nxt = sv_prod[15:8];
    // hue * 6 as two shifted copies
    hue_x6        = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};
    s1_sector_nxt = hue_x6[10:8];
    hue_pos       = hue_x6[8:0];
    // 256 minus distance from the middle of the sector pair
    s1_scale_nxt  = hue_pos[8] ? (9'd256 - {1'b0, hue_pos[7:0]}) : hue_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_chroma_r <= s1_chroma_nxt;
      s1_bright_r <= in_data.brightness;
      s1_scale_r  <= s1_scale_nxt;
      s1_sector_r <= s1_sector_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: middle level and offset
  // ---------------------------------------------------------------
  hsv2rgb_pkg::comp_t   s2_mid_r, s2_mid_nxt;
  hsv2rgb_pkg::comp_t   s2_lo_r, s2_lo_nxt;
  hsv2rgb_pkg::comp_t   s2_hi_r;
  hsv2rgb_pkg::sector_t s2_sector_r;

  logic [16:0] cx_prod;

  always_comb begin
    cx_prod    = {9'd0, s1_chroma_r} * {8'd0, s1_scale_r};
    s2_mid_nxt = cx_prod[15:8];
    s2_lo_nxt  = s1_bright_r - s1_chroma_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // chroma plus offset is brightness itself
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_mid_r    <= s2_mid_nxt;
      s2_lo_r     <= s2_lo_nxt;
      s2_hi_r     <= s1_bright_r;
      s2_sector_r <= s1_sector_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: add offset to the middle level, route by sector
  // ---------------------------------------------------------------
  hsv2rgb_pkg::comp_t s3_mid;
  hsv2rgb_pkg::rgb_t  s3_rgb_nxt, s3_rgb_r;

  assign s3_mid = s2_mid_r + s2_lo_r;

  hsv2rgb_mix u_mix (
    .sector (s2_sector_r),
    .hi     (s2_hi_r),
    .mid    (s3_mid),
    .lo     (s2_lo_r),
    .rgb    (s3_rgb_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_rgb_r <= s3_rgb_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_rgb_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted item did not reach stage 1");

  a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_ready) |=> (s2_valid_r && $stable(s2_mid_r)
      && $stable(s2_lo_r) && $stable(s2_sector_r)))
    else $error("stage 2 item changed while stalled");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_sector_r <= hsv2rgb_pkg::SEC_MAGENTA_RED))
    else $error("sector out of range");

  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> ({1'b0, s2_mid_r} + {1'b0, s2_lo_r} <= {1'b0, s2_hi_r}))
    else $error("middle level plus offset exceeds brightness");

endmodule

`default_nettype wire
